[src/trs_mmb_pkg.sv]
`default_nettype none
package trs_mmb_pkg;

   localparam int ANG_W        = 16;
   localparam int FIX_W        = 32;
   localparam int PROD_W       = 2 * FIX_W;
   localparam int FRAC_W       = 16;
   localparam int ROW_W        = 2;
   localparam int CORDIC_STEPS = 20;
   localparam int CORDIC_W     = 34;
   localparam int FOLD_W       = 36;
   localparam int ANG_SHIFT    = 18;
   localparam int OUT_SHIFT    = 14;
   localparam int FOLD_PASSES  = 3;
   // fold stage + iterations + output stage
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   // six matrix stages after the CORDIC lanes
   localparam int PIPE_DEPTH   = CORDIC_LAT + 6;
   localparam int REQ_W        = 9 * FIX_W - 3 * (FIX_W - ANG_W);
   localparam int RSP_W        = ((ROW_W + 4 * FIX_W + 7) / 8) * 8;

   localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

   typedef logic signed [FIX_W-1:0] fix_type;
   typedef fix_type [2:0] vec3_type;

   localparam fix_type FIX_MAX = 32'sh7fff_ffff;
   localparam fix_type FIX_MIN = 32'sh8000_0000;
   localparam fix_type ONE_Q16 = 32'sd65536;

   localparam logic signed [FOLD_W-1:0]   PI_Q30      = 36'sd3373259426;
   localparam logic signed [FOLD_W-1:0]   HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 34'sd652032874;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CORDIC_W-1:0] v;
      case (idx)
         5'd0:    v = 34'sd843314857;
         5'd1:    v = 34'sd497837830;
         5'd2:    v = 34'sd263043837;
         5'd3:    v = 34'sd133525159;
         5'd4:    v = 34'sd67021687;
         5'd5:    v = 34'sd33543515;
         5'd6:    v = 34'sd16775850;
         5'd7:    v = 34'sd8388437;
         5'd8:    v = 34'sd4194283;
         5'd9:    v = 34'sd2097150;
         5'd10:   v = 34'sd1048576;
         5'd11:   v = 34'sd524288;
         5'd12:   v = 34'sd262144;
         5'd13:   v = 34'sd131072;
         5'd14:   v = 34'sd65536;
         5'd15:   v = 34'sd32768;
         5'd16:   v = 34'sd16384;
         5'd17:   v = 34'sd8192;
         5'd18:   v = 34'sd4096;
         5'd19:   v = 34'sd2048;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q16.16 product scaling: floor shift, then saturate
   function automatic fix_type qscale(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-FRAC_W-1:0] s;
      fix_type r;
      s = p[PROD_W-1:FRAC_W];
      if (s > (PROD_W-FRAC_W)'(FIX_MAX))      r = FIX_MAX;
      else if (s < (PROD_W-FRAC_W)'(FIX_MIN)) r = FIX_MIN;
      else                                    r = s[FIX_W-1:0];
      return r;
   endfunction

   function automatic fix_type sat_add(input fix_type a, input fix_type b);
      logic signed [FIX_W:0] s;
      fix_type r;
      s = {a[FIX_W-1], a} + {b[FIX_W-1], b};
      if (s[FIX_W] != s[FIX_W-1]) r = s[FIX_W] ? FIX_MIN : FIX_MAX;
      else                        r = s[FIX_W-1:0];
      return r;
   endfunction

   function automatic fix_type neg_sat(input fix_type a);
      return (a == FIX_MIN) ? FIX_MAX : -a;
   endfunction

endpackage
`default_nettype wire

[src/trs_mmb_cordic.sv]
`default_nettype none
// One sine/cosine lane: fold stage, one register per CORDIC step, output stage.
module trs_mmb_cordic (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic signed [trs_mmb_pkg::ANG_W-1:0] angle,
   output trs_mmb_pkg::fix_type                     sin_q,
   output trs_mmb_pkg::fix_type                     cos_q
);

   localparam int N  = trs_mmb_pkg::CORDIC_STEPS;
   localparam int CW = trs_mmb_pkg::CORDIC_W;

   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [CW-1:0] z_ff [N];
   logic                 flip_ff [N+1];
   logic                 zero_ff [N+1];
   logic signed [CW-1:0] x_in [N+1];
   logic signed [CW-1:0] y_in [N+1];
   logic signed [CW-1:0] z_in [N];

   logic signed [trs_mmb_pkg::FOLD_W-1:0] fold;
   logic                                  flip_in;
   logic signed [CW-1:0]                  xf, yf, xs, ys;
   trs_mmb_pkg::fix_type                  sin_ff, cos_ff;

   // bring the angle into [-pi/2, pi/2], one pi at a time
   always_comb begin
      fold = {{(trs_mmb_pkg::FOLD_W - trs_mmb_pkg::ANG_W){angle[trs_mmb_pkg::ANG_W-1]}},
              angle} <<< trs_mmb_pkg::ANG_SHIFT;
      flip_in = 1'b0;
      for (int k = 0; k < trs_mmb_pkg::FOLD_PASSES; k++) begin
         if (fold > trs_mmb_pkg::HALF_PI_Q30) begin
            fold    = fold - trs_mmb_pkg::PI_Q30;
            flip_in = ~flip_in;
         end else if (fold < -trs_mmb_pkg::HALF_PI_Q30) begin
            fold    = fold + trs_mmb_pkg::PI_Q30;
            flip_in = ~flip_in;
         end
      end
      x_in[0] = trs_mmb_pkg::GAIN_Q30;
      y_in[0] = '0;
      z_in[0] = fold[CW-1:0];
      // one rotation per step, direction from the sign of the residual angle
      for (int k = 0; k < N; k++) begin
         if (z_ff[k] >= 0) begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
         end else begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
         end
      end
      // residual angle after the last step is not needed
      for (int k = 1; k < N; k++) begin
         if (z_ff[k-1] >= 0) z_in[k] = z_ff[k-1] - trs_mmb_pkg::atan_q30(5'(k-1));
         else                z_in[k] = z_ff[k-1] + trs_mmb_pkg::atan_q30(5'(k-1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= N; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
         end
         for (int k = 0; k < N; k++) z_ff[k] <= z_in[k];
         flip_ff[0] <= flip_in;
         zero_ff[0] <= (angle == '0);
         for (int k = 1; k <= N; k++) begin
            flip_ff[k] <= flip_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   always_comb begin
      xf = flip_ff[N] ? -x_ff[N] : x_ff[N];
      yf = flip_ff[N] ? -y_ff[N] : y_ff[N];
      xs = xf >>> trs_mmb_pkg::OUT_SHIFT;
      ys = yf >>> trs_mmb_pkg::OUT_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[N]) begin
            sin_ff <= '0;
            cos_ff <= trs_mmb_pkg::ONE_Q16;
         end else begin
            sin_ff <= ys[trs_mmb_pkg::FIX_W-1:0];
            cos_ff <= xs[trs_mmb_pkg::FIX_W-1:0];
         end
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule
`default_nettype wire

[src/trs_model_matrix_builder_top.sv]
`default_nettype none
// TRS model matrix builder, Euler XYZ order.
// Slave channel req_*: one request per object carries position, three Q4.12
// angles and per-axis Q16.16 scale. Master channel rsp_*: four transfers per
// object, rows 0..3 of M = T*Rx*Ry*Rz*S, rsp_tlast high on row 3.
// Sine and cosine come from three 20-step CORDIC lanes, one register per
// step; two matrix products and the scale follow in six register stages.
// Row 0 is shown once the object is loaded from the last stage into the row
// buffer, then one row a cycle while rsp_tready is high.
// The four rows of each object share the single result channel. Up to 28
// objects are in flight in the pipeline.
// Stall: the pipeline advances as one; it moves whenever its last stage is
// empty or its object is being loaded into the row buffer. req_tready drops
// only while the last stage holds an object the busy row buffer cannot take.
// Nothing is lost or repeated while rsp_tready is low.
// Reset: synchronous, active high; clears all valid bits and the row
// buffer's valid flag and row index. No configuration, no clearing pass.
module trs_model_matrix_builder_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
   input  wire logic [trs_mmb_pkg::REQ_W-1:0]   req_tdata,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // row_index, col0, col1, col2, col3, zero pad
   output      logic [trs_mmb_pkg::RSP_W-1:0]   rsp_tdata,
   // last_row
   output      logic                            rsp_tlast
);

   localparam int D    = trs_mmb_pkg::PIPE_DEPTH;
   localparam int S_M1 = trs_mmb_pkg::CORDIC_LAT;
   localparam int S_M4 = S_M1 + 3;
   localparam int S_M5 = S_M1 + 4;
   localparam int FW   = trs_mmb_pkg::FIX_W;
   localparam int AW   = trs_mmb_pkg::ANG_W;
   localparam int PW   = trs_mmb_pkg::PROD_W;
   localparam int AOFF = 3 * FW;
   localparam int SOFF = 3 * FW + 3 * AW;

   typedef logic signed [PW-1:0] prod_type;

   // pipeline control
   logic                   valid_ff [D];
   logic                   adv, ser_free, load, rsp_fire;
   trs_mmb_pkg::vec3_type  pos_ff [D];
   trs_mmb_pkg::vec3_type  scl_ff [S_M5];
   trs_mmb_pkg::vec3_type  req_pos, req_scl;

   // trig lanes, axis order x, y, z
   trs_mmb_pkg::fix_type   sin_w [3];
   trs_mmb_pkg::fix_type   cos_w [3];

   // matrix stages
   prod_type               p1_ff [4];
   trs_mmb_pkg::fix_type   trig_ff [6];      // cx, sx, cy, sy, cz, sz
   trs_mmb_pkg::vec3_type  rxy_ff [3];
   trs_mmb_pkg::fix_type   cz2_ff, sz2_ff;
   prod_type               p3_ff [3][4];
   trs_mmb_pkg::fix_type   a2_ff [3];
   trs_mmb_pkg::vec3_type  r_ff [3];
   prod_type               p5_ff [3][3];
   trs_mmb_pkg::vec3_type  m_ff [3];
   trs_mmb_pkg::fix_type   nsx, nsy, nsz;

   // row buffer
   logic                               hold_v_ff;
   logic [trs_mmb_pkg::ROW_W-1:0]      row_ff;
   trs_mmb_pkg::vec3_type              mat_ff [3];
   trs_mmb_pkg::vec3_type              tpos_ff;
   trs_mmb_pkg::fix_type               c0, c1, c2, c3;

   assign rsp_fire   = hold_v_ff && rsp_tready;
   assign ser_free   = !hold_v_ff || (rsp_tready && row_ff == trs_mmb_pkg::LAST_ROW);
   assign adv        = !valid_ff[D-1] || ser_free;
   assign load       = valid_ff[D-1] && ser_free;
   assign req_tready = adv;

   for (genvar a = 0; a < 3; a++) begin : g_unpack
      assign req_pos[a] = req_tdata[a*FW +: FW];
      assign req_scl[a] = req_tdata[SOFF + a*FW +: FW];
      trs_mmb_cordic u_lane (
         .clock (clock),
         .en    (adv),
         .angle (req_tdata[AOFF + a*AW +: AW]),
         .sin_q (sin_w[a]),
         .cos_q (cos_w[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < D; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < D; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff[0] <= req_pos;
         scl_ff[0] <= req_scl;
         for (int k = 1; k < D; k++) pos_ff[k] <= pos_ff[k-1];
         for (int k = 1; k < S_M5; k++) scl_ff[k] <= scl_ff[k-1];
      end
   end

   always_comb begin
      nsx = trs_mmb_pkg::neg_sat(sin_w[0]);
      nsy = trs_mmb_pkg::neg_sat(sin_w[1]);
      nsz = trs_mmb_pkg::neg_sat(sz2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // M1: products for Rx*Ry
         p1_ff[0]   <= nsx * nsy;
         p1_ff[1]   <= nsx * cos_w[1];
         p1_ff[2]   <= cos_w[0] * nsy;
         p1_ff[3]   <= cos_w[0] * cos_w[1];
         trig_ff[0] <= cos_w[0];
         trig_ff[1] <= sin_w[0];
         trig_ff[2] <= cos_w[1];
         trig_ff[3] <= sin_w[1];
         trig_ff[4] <= cos_w[2];
         trig_ff[5] <= sin_w[2];

         // M2: Rx*Ry, terms against zero or one drop out exactly
         rxy_ff[0] <= {trig_ff[3], trs_mmb_pkg::fix_type'(0), trig_ff[2]};
         rxy_ff[1] <= {trs_mmb_pkg::qscale(p1_ff[1]), trig_ff[0],
                       trs_mmb_pkg::qscale(p1_ff[0])};
         rxy_ff[2] <= {trs_mmb_pkg::qscale(p1_ff[3]), trig_ff[1],
                       trs_mmb_pkg::qscale(p1_ff[2])};
         cz2_ff    <= trig_ff[4];
         sz2_ff    <= trig_ff[5];

         // M3: products for (Rx*Ry)*Rz
         for (int i = 0; i < 3; i++) begin
            p3_ff[i][0] <= rxy_ff[i][0] * cz2_ff;
            p3_ff[i][1] <= rxy_ff[i][1] * sz2_ff;
            p3_ff[i][2] <= rxy_ff[i][0] * nsz;
            p3_ff[i][3] <= rxy_ff[i][1] * cz2_ff;
            a2_ff[i]    <= rxy_ff[i][2];
         end

         // M4: rotation matrix
         for (int i = 0; i < 3; i++) begin
            r_ff[i][0] <= trs_mmb_pkg::sat_add(trs_mmb_pkg::qscale(p3_ff[i][0]),
                                               trs_mmb_pkg::qscale(p3_ff[i][1]));
            r_ff[i][1] <= trs_mmb_pkg::sat_add(trs_mmb_pkg::qscale(p3_ff[i][2]),
                                               trs_mmb_pkg::qscale(p3_ff[i][3]));
            r_ff[i][2] <= a2_ff[i];
         end

         // M5: column scale products
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               p5_ff[i][j] <= r_ff[i][j] * scl_ff[S_M4][j];

         // M6: scaled matrix
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               m_ff[i][j] <= trs_mmb_pkg::qscale(p5_ff[i][j]);
      end
   end

   // row buffer: holds one finished object and plays out its four rows
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         row_ff    <= '0;
      end else if (load) begin
         hold_v_ff <= 1'b1;
         row_ff    <= '0;
      end else if (rsp_fire) begin
         if (row_ff == trs_mmb_pkg::LAST_ROW) hold_v_ff <= 1'b0;
         row_ff <= row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) mat_ff[i] <= m_ff[i];
         tpos_ff <= pos_ff[D-1];
      end
   end

   always_comb begin
      unique case (row_ff)
         2'd0: begin
            c0 = mat_ff[0][0]; c1 = mat_ff[0][1]; c2 = mat_ff[0][2]; c3 = tpos_ff[0];
         end
         2'd1: begin
            c0 = mat_ff[1][0]; c1 = mat_ff[1][1]; c2 = mat_ff[1][2]; c3 = tpos_ff[1];
         end
         2'd2: begin
            c0 = mat_ff[2][0]; c1 = mat_ff[2][1]; c2 = mat_ff[2][2]; c3 = tpos_ff[2];
         end
         default: begin
            c0 = '0; c1 = '0; c2 = '0; c3 = trs_mmb_pkg::ONE_Q16;
         end
      endcase
   end

   assign rsp_tvalid = hold_v_ff;
   assign rsp_tlast  = (row_ff == trs_mmb_pkg::LAST_ROW);
   assign rsp_tdata  = {{(trs_mmb_pkg::RSP_W - trs_mmb_pkg::ROW_W - 4*FW){1'b0}},
                        c3, c2, c1, c0, row_ff};

endmodule
`default_nettype wire

[src/trs_mmb_checker.sv]
`default_nettype none
module trs_mmb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [trs_mmb_pkg::RSP_W-1:0] rsp_tdata,
   input wire logic                          rsp_tlast
);

   logic [trs_mmb_pkg::ROW_W-1:0] row;
   assign row = rsp_tdata[trs_mmb_pkg::ROW_W-1:0];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_rows_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && row == $past(row) + 1'b1)
      else $error("rows of one object not contiguous");

   a_last_on_row3: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (row == trs_mmb_pkg::LAST_ROW))
      else $error("tlast does not match row 3");

   a_first_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) && !$past(reset) |-> row == '0)
      else $error("object does not start on row 0");

endmodule

bind trs_model_matrix_builder_top trs_mmb_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

[sim/trs_model_matrix_builder_top_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module trs_model_matrix_builder_top_test;

   localparam int N_RANDOM    = 156;
   localparam int CYCLE_LIMIT = 200000;

   // one object: pos, angles, scale
   typedef struct {
      logic signed [31:0] pos [3];
      logic signed [15:0] ang [3];
      logic signed [31:0] scl [3];
   } trs_item_type;

   typedef struct {
      logic [1:0]         row;
      logic signed [31:0] col [4];
      logic               last;
   } matrix_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [trs_mmb_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [trs_mmb_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;

   trs_item_type   pending_items [$];
   matrix_row_type expected_rows [$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  stimulus_done = 1'b0;
   logic req_fire_ff = 1'b0;
   logic rsp_fire_ff = 1'b0;

   trs_model_matrix_builder_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   // ---- predictor ----
   function automatic longint floor_shift(longint v, int n);
      return v >>> n;   // arithmetic shift floors in SV
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fix_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(floor_shift(p, 16));
   endfunction

   // sine and cosine of a Q4.12 angle via folded 20-step CORDIC
   task automatic sine_cosine(input logic signed [15:0] a,
                              output logic signed [31:0] s,
                              output logic signed [31:0] c);
      longint z, x, y, xs, ys;
      longint atan_tab [20];
      bit flip;
      atan_tab = '{843314857, 497837830, 263043837, 133525159, 67021687,
                   33543515, 16775850, 8388437, 4194283, 2097150,
                   1048576, 524288, 262144, 131072, 65536,
                   32768, 16384, 8192, 4096, 2048};
      flip = 1'b0;
      if (a == 0) begin
         s = '0;
         c = 32'sd65536;
         return;
      end
      z = longint'(a) * 262144;
      while (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         flip = ~flip;
      end
      while (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         flip = ~flip;
      end
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 20; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_tab[i];
         end else begin
            x += ys; y -= xs; z += atan_tab[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clamp32(floor_shift(x, 14));
      s = clamp32(floor_shift(y, 14));
   endtask

   typedef logic signed [31:0] mat3_type [3][3];

   function automatic mat3_type mat3_product(mat3_type a, mat3_type b);
      mat3_type r;
      longint acc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += longint'(fix_mul(a[i][k], b[k][j]));
            r[i][j] = clamp32(acc);
         end
      return r;
   endfunction

   task automatic predict_model_rows(input trs_item_type it);
      logic signed [31:0] sn [3], cs [3];
      mat3_type rx, ry, rz, r;
      matrix_row_type mr;
      for (int a = 0; a < 3; a++) sine_cosine(it.ang[a], sn[a], cs[a]);
      rx = '{'{32'sd65536, 0, 0}, '{0, cs[0], clamp32(-longint'(sn[0]))},
             '{0, sn[0], cs[0]}};
      ry = '{'{cs[1], 0, sn[1]}, '{0, 32'sd65536, 0},
             '{clamp32(-longint'(sn[1])), 0, cs[1]}};
      rz = '{'{cs[2], clamp32(-longint'(sn[2])), 0}, '{sn[2], cs[2], 0},
             '{0, 0, 32'sd65536}};
      r = mat3_product(mat3_product(rx, ry), rz);
      for (int i = 0; i < 4; i++) begin
         mr.row = i[1:0];
         for (int j = 0; j < 3; j++) mr.col[j] = (i < 3) ? fix_mul(r[i][j], it.scl[j]) : '0;
         mr.col[3] = (i < 3) ? it.pos[i] : 32'sd65536;
         mr.last = (i == 3);
         expected_rows = {expected_rows, mr};
      end
   endtask

   function automatic logic [trs_mmb_pkg::REQ_W-1:0] pack_item(trs_item_type it);
      return {it.scl[2], it.scl[1], it.scl[0], it.ang[2], it.ang[1], it.ang[0],
              it.pos[2], it.pos[1], it.pos[0]};
   endfunction

   function automatic logic signed [31:0] rand_fix(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
         default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      endcase
   endfunction

   function automatic trs_item_type random_item();
      trs_item_type it;
      int m;
      m = $urandom_range(0, 3);
      for (int a = 0; a < 3; a++) begin
         it.pos[a] = (m == 0) ? rand_fix(0) : rand_fix(2);
         it.scl[a] = (m == 0) ? rand_fix(0) : rand_fix(1);
         case ($urandom_range(0, 5))
            0:       it.ang[a] = '0;
            1, 2:    it.ang[a] = 16'($urandom);
            default: it.ang[a] = $signed(16'($urandom_range(0, 26000))) - 16'sd13000;
         endcase
      end
      return it;
   endfunction

   // ---- stimulus ----
   initial begin
      trs_item_type it;
      logic signed [15:0] ang_list [8];
      logic signed [31:0] fix_list [6];
      ang_list = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd6434, -16'sd6434,
                   16'sd12868, 16'sd1, -16'sd1};
      fix_list = '{32'sd0, 32'sh7fffffff, 32'sh80000000, 32'sd65536,
                   -32'sd65536, 32'sd1};
      // zero angles: identity rotation, extremes of position and scale
      for (int k = 0; k < 6; k++) begin
         for (int a = 0; a < 3; a++) begin
            it.pos[a] = fix_list[(k + a) % 6];
            it.ang[a] = '0;
            it.scl[a] = fix_list[(k + 2 * a) % 6];
         end
         pending_items = {pending_items, it};
      end
      // angle extremes, quarter and half turns, saturating scales
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < 3; a++) begin
            it.pos[a] = fix_list[(k + a + 1) % 6];
            it.ang[a] = ang_list[(k + 3 * a) % 8];
            it.scl[a] = (k < 4) ? fix_list[1 + (k % 2)] : 32'sd65536;
         end
         pending_items = {pending_items, it};
      end
      for (int n = 0; n < N_RANDOM; n++) pending_items = {pending_items, random_item()};
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 1'b0;
   end

   // handshakes as seen at the rising edge
   always @(posedge clock) begin
      req_fire_ff <= !reset && req_tvalid && req_tready;
      rsp_fire_ff <= !reset && rsp_tvalid && rsp_tready;
   end

   // ---- driver ----
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire_ff) begin
            // request taken on the last rising edge
            predict_model_rows(pending_items.pop_front());
            req_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
         end
         if (req_tvalid && !req_fire_ff) begin
            // hold
         end else if (pending_items.size() == 0) begin
            req_tvalid <= 1'b0;
            stimulus_done = 1'b1;
         end else if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pack_item(pending_items[0]);
         end
      end
   end

   // result side back-pressure
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire_ff)
            rsp_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---- monitor ----
   always @(posedge clock) begin
      matrix_row_type want;
      logic signed [31:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected row, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_tdata[1:0] !== want.row) begin
               $display("%0t: row_index expected %0d actual %0d", $time, want.row,
                        rsp_tdata[1:0]);
               fail_count++;
            end
            for (int j = 0; j < 4; j++) begin
               got = rsp_tdata[2 + 32 * j +: 32];
               if (got !== want.col[j]) begin
                  $display("%0t: row %0d col%0d expected %h actual %h", $time,
                           want.row, j, want.col[j], got);
                  fail_count++;
               end
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_row expected %0b actual %0b", $time, want.last,
                        rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // ---- end of run and timeout ----
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("trs_model_matrix_builder_top verification failed");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_rows.size() == 0);
      repeat (trs_mmb_pkg::PIPE_DEPTH + 10) @(posedge clock);
      if (fail_count == 0 && expected_rows.size() == 0) begin
         $display("trs_model_matrix_builder_top verification clean");
      end else begin
         $display("trs_model_matrix_builder_top verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

[trs_model_matrix_builder_top.f]
src/trs_mmb_pkg.sv
src/trs_mmb_cordic.sv
src/trs_model_matrix_builder_top.sv
src/trs_mmb_checker.sv
sim/trs_model_matrix_builder_top_test.sv
